[hw/rtl/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg
// shared types and character constants of the punctuation spacing tokenizer
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int WIN_DEPTH = 8;
	localparam int SLOTS     = 3;
	localparam int BACK_MAX  = 5;
	localparam int OUT_MAX   = 9;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] seen_t;
	typedef logic [1:0] pend_t;
	typedef logic [3:0] cnt_t;

	localparam seen_t SEEN_MAX = 3'd7;

	localparam byte_t CH_DOT   = 8'h2E;
	localparam byte_t CH_COMMA = 8'h2C;
	localparam byte_t CH_DASH  = 8'h2D;
	localparam byte_t CH_APOS  = 8'h27;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_NL    = 8'h0A;
	localparam byte_t CH_Z     = 8'h7A;
	localparam byte_t CH_N     = 8'h6E;
	localparam byte_t CH_NONE  = 8'h00;

	// output history carried from one decision to the next
	typedef struct packed {
		byte_t prev_char;
		logic  emitted;
	} ctx_t;

endpackage

[hw/rtl/punctuation_spacing_tokenizer.sv]
// ----------------------------------------------------------------------------
// punctuation_spacing_tokenizer
// copies a byte stream and places spaces around non-word characters
// ----------------------------------------------------------------------------
// Input channel item_valid/item_stall carries char_in and end_of_text, one
// text byte per transfer; end_of_text marks the last byte of a text. Output
// channel result_valid/result_stall carries char_out and last_out, one byte
// per transfer; last_out marks the final byte of the text.
// An accepted byte waits in the input register, is decided against the
// byte window and the output history, and its bytes are registered in
// the result register, from which they are offered.
// Each byte is decided once two later bytes are known, so output lags input
// by two bytes; end_of_text decides the pending bytes at once (up to nine
// output bytes). The result port moves one byte a cycle while result_stall
// is low. An item makes up to three output bytes in mid text, one to nine
// at end of text, and an item that makes none leaves the result register
// untouched.
// The result register takes a new item in the cycle its last byte leaves.
// While result_stall is high the result bytes hold, and item_stall rises
// once the input register holds an item with output bytes. Reset clears
// the window and history; the end-of-text item returns the state to reset.
// ----------------------------------------------------------------------------
module punctuation_spacing_tokenizer import pst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  byte_t char_in,
	input  logic  end_of_text,
	output logic  result_valid,
	input  logic  result_stall,
	output byte_t char_out,
	output logic  last_out
);

	logic  valid_s1;
	byte_t char_s1;
	logic  eot_s1;

	byte_t window_q [WIN_DEPTH];
	seen_t seen_q;
	pend_t pending_q;
	ctx_t  ctx_q;

	byte_t win_c [WIN_DEPTH];
	pend_t pend_new;
	logic  active [SLOTS];
	byte_t cur_c [SLOTS];
	byte_t next1_c [SLOTS];
	byte_t next2_c [SLOTS];
	byte_t back_c [SLOTS][BACK_MAX];
	seen_t seen_c [SLOTS + 1];
	ctx_t  ctx_c [SLOTS + 1];
	ctx_t  ctx_d [SLOTS];
	logic  pre_c [SLOTS];
	logic  post_c [SLOTS];

	byte_t list_c [OUT_MAX];
	cnt_t  list_cnt;

	logic  buf_free;
	logic  buf_load;
	logic  s1_go;
	logic  accept;

	assign s1_go      = valid_s1 && (list_cnt == '0 || buf_free);
	assign buf_load   = s1_go && (list_cnt != '0);
	assign item_stall = valid_s1 && !s1_go;
	assign accept     = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_in;
			eot_s1  <= end_of_text;
		end
	end

	// shifted window and which positions get decided
	always_comb begin
		for (int i = 0; i < WIN_DEPTH - 1; i++) begin
			win_c[i] = window_q[i + 1];
		end
		win_c[WIN_DEPTH - 1] = char_s1;
		pend_new = ((pending_q == 2'd3) ? 2'd2 : pending_q) + 2'd1;

		active[0] = (pend_new == 2'd3);
		active[1] = eot_s1 && (pend_new >= 2'd2);
		active[2] = eot_s1;

		for (int j = 0; j < SLOTS; j++) begin
			cur_c[j] = win_c[WIN_DEPTH - SLOTS + j];
			for (int k = 0; k < BACK_MAX; k++) begin
				back_c[j][k] = win_c[WIN_DEPTH - SLOTS + j - k - 1];
			end
		end
		next1_c[0] = win_c[WIN_DEPTH - 2];
		next2_c[0] = win_c[WIN_DEPTH - 1];
		next1_c[1] = win_c[WIN_DEPTH - 1];
		next2_c[1] = CH_NONE;
		next1_c[2] = CH_NONE;
		next2_c[2] = CH_NONE;
	end

	// decision chain, oldest pending byte first
	assign seen_c[0] = seen_q;
	assign ctx_c[0]  = ctx_q;

	for (genvar j = 0; j < SLOTS; j++) begin : g_slot
		pst_decide u_decide (
			.cur     (cur_c[j]),
			.next1   (next1_c[j]),
			.next2   (next2_c[j]),
			.back    (back_c[j]),
			.seen    (seen_c[j]),
			.ctx_i   (ctx_c[j]),
			.pre_sp  (pre_c[j]),
			.post_sp (post_c[j]),
			.ctx_o   (ctx_d[j])
		);

		assign ctx_c[j + 1]  = active[j] ? ctx_d[j] : ctx_c[j];
		assign seen_c[j + 1] = (active[j] && seen_c[j] != SEEN_MAX) ?
			seen_c[j] + 3'd1 : seen_c[j];
	end

	// pack the output bytes of the item
	always_comb begin
		cnt_t off;
		off = '0;
		for (int e = 0; e < OUT_MAX; e++) begin
			list_c[e] = CH_SPACE;
		end
		for (int j = 0; j < SLOTS; j++) begin
			if (active[j] && pre_c[j]) begin
				list_c[off] = CH_SPACE;
				off = off + cnt_t'(1);
			end
			if (active[j]) begin
				list_c[off] = cur_c[j];
				off = off + cnt_t'(1);
			end
			if (active[j] && post_c[j]) begin
				list_c[off] = CH_SPACE;
				off = off + cnt_t'(1);
			end
		end
		list_cnt = off;
	end

	// window and output history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				window_q[i] <= CH_NONE;
			end
			seen_q    <= '0;
			pending_q <= '0;
			ctx_q     <= '0;
		end else if (s1_go) begin
			if (eot_s1) begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					window_q[i] <= CH_NONE;
				end
				seen_q    <= '0;
				pending_q <= '0;
				ctx_q     <= '0;
			end else begin
				window_q  <= win_c;
				seen_q    <= seen_c[SLOTS];
				pending_q <= (pend_new == 2'd3) ? 2'd2 : pend_new;
				ctx_q     <= ctx_c[SLOTS];
			end
		end
	end

	pst_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (buf_load),
		.load_bytes   (list_c),
		.load_cnt     (list_cnt),
		.load_last    (eot_s1),
		.free         (buf_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.char_out     (char_out),
		.last_out     (last_out)
	);

	// an empty input register never holds off the sender
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall)
		else $error("item_stall with empty input register");

	// end of text always yields at least one byte
	a_eot_output: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && eot_s1) |-> (list_cnt != '0))
		else $error("end of text produced no output");

	// a finished text leaves the state at its reset value
	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && eot_s1) |=> (seen_q == '0 && pending_q == '0 && !ctx_q.emitted))
		else $error("state not cleared after end of text");

	// a byte in mid text yields at most space, byte, space
	a_mid_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && !eot_s1) |-> (list_cnt <= cnt_t'(3)))
		else $error("too many bytes for one item in mid text");

endmodule

[hw/rtl/pst_decide.sv]
// ----------------------------------------------------------------------------
// pst_decide
// word/non-word decision for one byte and the spaces placed around it
// ----------------------------------------------------------------------------
module pst_decide import pst_pkg::*; (
	input  byte_t cur,
	input  byte_t next1,
	input  byte_t next2,
	input  byte_t back [BACK_MAX],
	input  seen_t seen,
	input  ctx_t  ctx_i,
	output logic  pre_sp,
	output logic  post_sp,
	output ctx_t  ctx_o
);

	function automatic logic is_upper(input byte_t c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic logic is_lower(input byte_t c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic logic is_letter(input byte_t c);
		return is_upper(c) || is_lower(c);
	endfunction

	function automatic logic is_numeral(input byte_t c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alnum(input byte_t c);
		return is_letter(c) || is_numeral(c);
	endfunction

	function automatic logic ci(input byte_t c, input byte_t lower);
		return c == lower || c == (lower - 8'd32);
	endfunction

	logic  h1, h2, h3, h4, h5;
	byte_t b1, b2, b3, b4, b5;
	logic  dot, word;

	always_comb begin
		h1 = seen >= 3'd1;
		h2 = seen >= 3'd2;
		h3 = seen >= 3'd3;
		h4 = seen >= 3'd4;
		h5 = seen >= 3'd5;
		b1 = h1 ? back[0] : CH_NONE;
		b2 = h2 ? back[1] : CH_NONE;
		b3 = h3 ? back[2] : CH_NONE;
		b4 = h4 ? back[3] : CH_NONE;
		b5 = h5 ? back[4] : CH_NONE;
		dot = (cur == CH_DOT);

		word = is_alnum(cur) || cur == CH_SPACE;
		// separators between digits
		word = word || ((dot || cur == CH_COMMA) && h1 && is_numeral(b1) &&
			is_numeral(next1));
		// abbreviations and initials
		word = word || (dot && h1 && is_letter(b1) && is_letter(next1));
		word = word || (dot && h1 && is_letter(b1) && next1 == CH_SPACE && is_lower(next2));
		word = word || (dot && h2 && is_letter(b1) && !is_alnum(b2));
		// titles
		word = word || (dot && h5 && !is_alnum(b5) && ci(b4, "p") && b3 == "r" &&
			b2 == "o" && b1 == "f");
		word = word || (dot && h4 && !is_alnum(b4) && ci(b3, "d") && b2 == "h" && b1 == "r");
		word = word || (dot && h4 && !is_alnum(b4) && ci(b3, "d") && b2 == "r" && b1 == "s");
		word = word || (dot && h3 && !is_alnum(b3) && ci(b2, "d") && b1 == "r");
		word = word || (dot && h3 && !is_alnum(b3) && ci(b2, "i") && b1 == "r");
		word = word || (dot && h4 && !is_alnum(b4) && ci(b3, "i") && b2 == "n" && b1 == "g");
		word = word || (dot && h3 && !is_alnum(b3) && ci(b2, "m") && b1 == "w");
		word = word || (dot && h3 && !is_alnum(b3) && ci(b2, "m") && b1 == "r");
		// dash after two word characters, apostrophe in z'n
		word = word || (cur == CH_DASH && h2 && is_alnum(b1) && is_alnum(b2));
		word = word || (cur == CH_APOS && h1 && b1 == CH_Z && next1 == CH_N);

		pre_sp = !word && ctx_i.emitted && ctx_i.prev_char != CH_SPACE &&
			!(ctx_i.prev_char == CH_NL && cur == CH_NL);
		post_sp = !word && next1 != CH_NONE && next1 != CH_SPACE &&
			!(next1 == CH_NL && cur == CH_NL);

		ctx_o.prev_char = post_sp ? CH_SPACE : cur;
		ctx_o.emitted   = 1'b1;
	end

endmodule

[hw/rtl/pst_outbuf.sv]
// ----------------------------------------------------------------------------
// pst_outbuf
// result register: holds one decided item, if unstalled one transfer a cycle
// ----------------------------------------------------------------------------
module pst_outbuf import pst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  byte_t load_bytes [OUT_MAX],
	input  cnt_t  load_cnt,
	input  logic  load_last,
	output logic  free,
	output logic  result_valid,
	input  logic  result_stall,
	output byte_t char_out,
	output logic  last_out
);

	byte_t bytes_q [OUT_MAX];
	cnt_t  cnt_q;
	logic  last_q;
	logic  xfer;

	assign result_valid = (cnt_q != '0);
	assign xfer         = result_valid && !result_stall;
	assign free         = (cnt_q == '0) || (cnt_q == cnt_t'(1) && !result_stall);
	assign char_out     = bytes_q[0];
	assign last_out     = last_q && (cnt_q == cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= load_cnt;
			last_q <= load_last;
		end else if (xfer) begin
			cnt_q  <= cnt_q - cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_bytes;
		end else if (xfer) begin
			for (int i = 0; i < OUT_MAX - 1; i++) begin
				bytes_q[i] <= bytes_q[i + 1];
			end
		end
	end

endmodule

[sim/punctuation_spacing_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// punctuation_spacing_tokenizer_tb
// self-checking bench for the punctuation spacing tokenizer
// ----------------------------------------------------------------------------
// Feeds texts one byte per transfer. A short table covers single-byte texts,
// separators, titles, the apostrophe, dashes and newlines. Random texts
// follow, mixing known tokens with noise. Every accepted byte runs through a
// spacing predictor, and each output transfer is compared with the oldest
// expected byte. Both channels idle at random. The result side holds off
// once for a long stretch so that the input side stalls.
// ----------------------------------------------------------------------------
module punctuation_spacing_tokenizer_tb;
	import pst_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 470;

	typedef struct {
		byte_t ch;
		logic  last;
	} out_byte_t;

	typedef struct {
		byte_t       ch;
		logic        eot;
		int          nexp;
		logic [31:0] exp;
	} row_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  item_valid;
	logic  item_stall;
	byte_t char_in;
	logic  end_of_text;
	logic  result_valid;
	logic  result_stall;
	byte_t char_out;
	logic  last_out;

	out_byte_t spaced_q[$];
	out_byte_t made[$];
	out_byte_t want;
	int        fails = 0;
	int        cycles = 0;
	int        sent = 0;
	bit        calm = 1'b0;
	bit        hold_go = 1'b0;

	// predictor state
	byte_t win[WIN_DEPTH];
	seen_t seen;
	pend_t pend;
	byte_t prev_ch;
	logic  wrote;

	// nexp -1: predicted, otherwise the typed output bytes, right aligned
	row_t plan [22] = '{
		'{"A", 1'b1, 1, "A"},
		'{".", 1'b1, 1, "."},
		'{8'hFF, 1'b1, 1, 32'hFF},
		'{"a", 1'b0, 0, 32'h0},
		'{"b", 1'b0, 0, 32'h0},
		'{",", 1'b1, 4, "ab ,"},
		'{" ", 1'b0, -1, 32'h0},
		'{"d", 1'b0, -1, 32'h0},
		'{"r", 1'b0, -1, 32'h0},
		'{".", 1'b0, -1, 32'h0},
		'{"3", 1'b0, -1, 32'h0},
		'{",", 1'b0, -1, 32'h0},
		'{"5", 1'b0, -1, 32'h0},
		'{" ", 1'b0, -1, 32'h0},
		'{"z", 1'b0, -1, 32'h0},
		'{"'", 1'b0, -1, 32'h0},
		'{"n", 1'b0, -1, 32'h0},
		'{" ", 1'b0, -1, 32'h0},
		'{"a", 1'b0, -1, 32'h0},
		'{"-", 1'b0, -1, 32'h0},
		'{CH_NL, 1'b0, -1, 32'h0},
		'{CH_NL, 1'b1, -1, 32'h0}
	};

	string pieces [13] = '{" prof. ", " dr. ", " drs.", " dhr.", " ir. ", " ing.", " Mw.",
		" mr.", "z'n ", "3,5", "e.g. a", "ab-cd", "x\n\ny"};
	byte_t marks [6] = '{CH_DOT, CH_COMMA, CH_DASH, CH_APOS, CH_SPACE, CH_NL};

	punctuation_spacing_tokenizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.char_in     (char_in),
		.end_of_text (end_of_text),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.char_out    (char_out),
		.last_out    (last_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	function automatic bit is_letter(byte_t c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_numeral(byte_t c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alnum(byte_t c);
		return is_letter(c) || is_numeral(c);
	endfunction

	function automatic bit either_case(byte_t c, byte_t lower);
		return c == lower || c == byte_t'(lower - 8'd32);
	endfunction

	function automatic byte_t win_get(int p);
		return p < WIN_DEPTH ? win[p] : CH_NONE;
	endfunction

	function automatic void clear_spacing();
		foreach (win[i]) win[i] = CH_NONE;
		seen = '0;
		pend = '0;
		prev_ch = CH_NONE;
		wrote = 1'b0;
	endfunction

	function automatic void put_byte(byte_t c);
		made.push_back('{c, 1'b0});
		prev_ch = c;
		wrote = 1'b1;
	endfunction

	function automatic void space_byte_at(int p);
		byte_t o, n1, n2, b1, b2, b3, b4, b5;
		bit h1, h2, h3, h4, h5, dot, word;
		o = win_get(p);
		n1 = win_get(p + 1);
		n2 = win_get(p + 2);
		h1 = seen >= 1;
		h2 = seen >= 2;
		h3 = seen >= 3;
		h4 = seen >= 4;
		h5 = seen >= 5;
		b1 = h1 ? win[p - 1] : CH_NONE;
		b2 = h2 ? win[p - 2] : CH_NONE;
		b3 = h3 ? win[p - 3] : CH_NONE;
		b4 = h4 ? win[p - 4] : CH_NONE;
		b5 = h5 ? win[p - 5] : CH_NONE;
		dot = o == CH_DOT;
		word = is_alnum(o) || o == CH_SPACE;
		word |= (dot || o == CH_COMMA) && h1 && is_numeral(b1) && is_numeral(n1);
		word |= dot && h1 && is_letter(b1) && is_letter(n1);
		word |= dot && h1 && is_letter(b1) && n1 == CH_SPACE && n2 >= "a" && n2 <= "z";
		word |= dot && h2 && is_letter(b1) && !is_alnum(b2);
		word |= dot && h5 && !is_alnum(b5) && either_case(b4, "p") && b3 == "r"
			&& b2 == "o" && b1 == "f";
		word |= dot && h4 && !is_alnum(b4) && either_case(b3, "d") && b2 == "h" && b1 == "r";
		word |= dot && h4 && !is_alnum(b4) && either_case(b3, "d") && b2 == "r" && b1 == "s";
		word |= dot && h3 && !is_alnum(b3) && either_case(b2, "d") && b1 == "r";
		word |= dot && h3 && !is_alnum(b3) && either_case(b2, "i") && b1 == "r";
		word |= dot && h4 && !is_alnum(b4) && either_case(b3, "i") && b2 == "n" && b1 == "g";
		word |= dot && h3 && !is_alnum(b3) && either_case(b2, "m") && b1 == "w";
		word |= dot && h3 && !is_alnum(b3) && either_case(b2, "m") && b1 == "r";
		word |= o == CH_DASH && h2 && is_alnum(b1) && is_alnum(b2);
		word |= o == CH_APOS && h1 && b1 == CH_Z && n1 == CH_N;

		if (!word && wrote && prev_ch != CH_SPACE && !(prev_ch == CH_NL && o == CH_NL))
			put_byte(CH_SPACE);
		put_byte(o);
		if (!word && n1 != CH_NONE && n1 != CH_SPACE && !(n1 == CH_NL && o == CH_NL))
			put_byte(CH_SPACE);
		if (seen < SEEN_MAX)
			seen++;
	endfunction

	function automatic void space_text_byte(byte_t c, logic eot);
		made.delete();
		for (int i = 0; i < WIN_DEPTH - 1; i++)
			win[i] = win[i + 1];
		win[WIN_DEPTH - 1] = c;
		pend++;
		if (!eot) begin
			if (pend == 2'd3) begin
				space_byte_at(5);
				pend = 2'd2;
			end
		end else begin
			for (int p = WIN_DEPTH - pend; p < WIN_DEPTH; p++)
				space_byte_at(p);
			if (made.size() > 0)
				made[made.size() - 1].last = 1'b1;
			clear_spacing();
		end
	endfunction

	function automatic byte_t pick_char();
		case ($urandom_range(9))
			0, 1, 2: return byte_t'($urandom_range(97, 122));
			3:       return byte_t'($urandom_range(65, 90));
			4:       return byte_t'($urandom_range(48, 57));
			5, 6:    return marks[$urandom_range(5)];
			7:       return byte_t'($urandom_range(1, 255));
			default: return CH_SPACE;
		endcase
	endfunction

	task automatic send_byte(input byte_t c, input logic eot, input int nexp,
		input logic [31:0] exp);
		if (!calm && $urandom_range(99) < 13) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		char_in <= c;
		end_of_text <= eot;
		do @(posedge clk); while (item_stall);
		space_text_byte(c, eot);
		if (nexp < 0) begin
			foreach (made[k]) spaced_q.push_back(made[k]);
		end else begin
			for (int k = 0; k < nexp; k++)
				spaced_q.push_back('{exp[8 * (nexp - 1 - k) +: 8], eot && k == nexp - 1});
		end
		sent++;
		@(negedge clk);
	endtask

	// result side
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= !calm && $urandom_range(99) < 13;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (spaced_q.size() == 0) begin
				$error("unexpected transfer: char_out %h last_out %b", char_out, last_out);
				fails++;
			end else begin
				want = spaced_q.pop_front();
				if (char_out !== want.ch) begin
					$error("char_out: expected %h, got %h", want.ch, char_out);
					fails++;
				end
				if (last_out !== want.last) begin
					$error("last_out: expected %b, got %b", want.last, last_out);
					fails++;
				end
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		byte_t txt[$];
		string s;
		int len;
		clear_spacing();
		arst_n = 1'b0;
		item_valid = 1'b0;
		char_in = CH_SPACE;
		end_of_text = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[r])
			send_byte(plan[r].ch, plan[r].eot, plan[r].nexp, plan[r].exp);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			txt.delete();
			len = $urandom_range(3) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 24);
			while (txt.size() < len) begin
				if ($urandom_range(4) == 0) begin
					s = pieces[$urandom_range(12)];
					for (int k = 0; k < s.len(); k++) txt.push_back(s[k]);
				end else begin
					txt.push_back(pick_char());
				end
			end
			calm = sent >= 150 && sent < 300;
			if (sent >= 40)
				hold_go = 1'b1;
			foreach (txt[k])
				send_byte(txt[k], k == txt.size() - 1, -1, 32'h0);
		end
		item_valid <= 1'b0;
		calm = 1'b0;

		while (spaced_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
